// ===== rtl/ptpc_pkg.sv =====
// Shared widths, constants, register indexes and types of the probe calibration block.
package ptpc_pkg;

  // Field widths.
  localparam int MV_W  = 12;
  localparam int VAL_W = 20;
  localparam int T_W   = 15;
  localparam int RD_W  = 25;
  localparam int CFG_W = 20;
  localparam int IDX_W = 3;

  // Quotient width of the serial divider: one bit above the reading magnitude.
  localparam int Q_W = RD_W + 1;

  // Reading limits.
  localparam logic [Q_W-1:0] READ_MAX_Q = Q_W'(16777215);
  localparam logic [Q_W-1:0] READ_MIN_Q = Q_W'(16777216);
  localparam logic signed [RD_W-1:0] READ_MAX = RD_W'(16777215);
  localparam logic signed [RD_W-1:0] READ_MIN = RD_W'(-16777216);

  // Compensation: 1 + 0.02 * (T - 25) in centidegrees is (2500 + T) / 5000.
  localparam int SCALE_W = 14;
  localparam logic signed [SCALE_W-1:0] COMP_SCALE  = SCALE_W'(5000);
  localparam int T_OFFSET = 2500;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_P1_MV    = 3'd0,
    REG_P1_VALUE = 3'd1,
    REG_P2_MV    = 3'd2,
    REG_P2_VALUE = 3'd3,
    REG_CAL_RDY  = 3'd4,
    REG_TCOMP    = 3'd5
  } cfg_reg_t;

  // Status of the serial divider.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ===== rtl/ptpc_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, sticky overflow past the quotient.
module ptpc_sdiv import ptpc_pkg::*; #(
  parameter int DVD_W = 55,
  parameter int DVS_W = 37,
  parameter int STP_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [STP_W-1:0] steps,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [Q_W-1:0]   quotient,
  output div_stat_t        stat
);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;
  logic             ovf_r;
  logic [STP_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_nxt;

  // One trial subtraction per cycle.
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fits    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  // Shift the dividend through, collect quotient bits and remember any lost at the top.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        rem_r <= rem_nxt;
        q_r   <= {q_r[Q_W-2:0], fits};
        ovf_r <= ovf_r | q_r[Q_W-1];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

// ===== rtl/probe_two_point_calibration_top.sv =====
// Top level of the probe calibration block: moving mean, two-point line and compensation.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   func, sample_mv, temperature_centi
//   out_     output     out_valid / out_ready mean_mv, reading, reading_valid, saturated
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// A sample beat runs the shared bit-serial divider twice: once for the mean and once over the
// full calibration ratio, with the compensation steps in between when compensation is on.
// Without calibration ready the second pass is skipped, and a clear beat skips both passes.
// One beat is worked on at a time; the next is taken once the result sits in the output
// register, which holds it while out_ready is low. Reset is synchronous and clears the
// history, the configuration and both handshakes.
module probe_two_point_calibration_top import ptpc_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [MV_W-1:0]        in_sample_mv,
  input  logic signed [T_W-1:0]  in_temperature_centi,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MV_W-1:0]        out_mean_mv,
  output logic signed [RD_W-1:0] out_reading,
  output logic                   out_reading_valid,
  output logic                   out_saturated,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = MV_W + $clog2(WINDOW);
  localparam int DV_W    = MV_W + 1;
  localparam int N_W     = CNT_W + 1;
  localparam int A_W     = VAL_W + 1 + DV_W;
  localparam int AN_W    = A_W + N_W;
  localparam int B_W     = MV_W + CNT_W;
  localparam int C_W     = B_W + 1;
  localparam int DVAL_W  = VAL_W + 1;
  localparam int D_W     = DVAL_W + C_W;
  localparam int NUM0_W  = ((AN_W > D_W) ? AN_W : D_W) + 1;
  localparam int NUMC_W  = NUM0_W + SCALE_W;
  localparam int LO_W    = NUM0_W / 2;
  localparam int HI_W    = NUM0_W - LO_W;
  localparam int LOP_W   = LO_W + SCALE_W - 1;
  localparam int HIP_W   = HI_W + SCALE_W;
  localparam int DEN0_W  = DV_W + N_W;
  localparam int TC_W    = T_W + 1;
  localparam int DEN_W   = DEN0_W + TC_W;
  localparam int DVD_W   = NUMC_W + 1;
  localparam int STP_W   = $clog2(DVD_W + 1);
  localparam int MEAN_SH = DVD_W - SUM_W - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_MEAN, S_MEAN_W, S_CAL0, S_CAL1, S_CAL2, S_CAL3,
    S_CMP0, S_CMP1, S_DIVS, S_DIV_W, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [MV_W-1:0]  p1mv_r;
  logic [VAL_W-1:0] p1val_r;
  logic [MV_W-1:0]  p2mv_r;
  logic [VAL_W-1:0] p2val_r;
  logic             cal_rdy_r;
  logic             tcomp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1mv_r    <= '0;
      p1val_r   <= '0;
      p2mv_r    <= '0;
      p2val_r   <= '0;
      cal_rdy_r <= 1'b0;
      tcomp_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_P1_MV:    p1mv_r    <= cfg_wdata[MV_W-1:0];
        REG_P1_VALUE: p1val_r   <= cfg_wdata[VAL_W-1:0];
        REG_P2_MV:    p2mv_r    <= cfg_wdata[MV_W-1:0];
        REG_P2_VALUE: p2val_r   <= cfg_wdata[VAL_W-1:0];
        REG_CAL_RDY:  cal_rdy_r <= cfg_wdata[0];
        REG_TCOMP:    tcomp_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // History memory: the old entry is read on the same edge the new sample is written.
  logic [MV_W-1:0]   hist_mem [WINDOW];
  logic [MV_W-1:0]   hist_rd_r;
  logic [SLOT_W-1:0] slot_r;
  logic              in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc && !in_func) begin
      hist_mem[slot_r] <= in_sample_mv;
      hist_rd_r        <= hist_mem[slot_r];
    end
  end

  // Running sum and fill count.
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             full;
  logic [MV_W-1:0]  sample_r;
  logic signed [T_W-1:0] temp_r;

  assign full    = (cnt_r == CNT_W'(WINDOW));
  assign sum_nxt = sum_r - (full ? SUM_W'(hist_rd_r) : '0) + SUM_W'(sample_r);

  // Calibration arithmetic; each step registers its products.
  logic signed [DV_W-1:0]   dv;
  logic signed [N_W-1:0]    n_s;
  logic signed [VAL_W:0]    v1_s;
  logic signed [DVAL_W-1:0] dval;
  logic signed [A_W-1:0]    a_prod, a_r;
  logic signed [AN_W-1:0]   an_prod, an_r;
  logic [B_W-1:0]           b_prod, b_r;
  logic signed [C_W-1:0]    c_nxt, c_r;
  logic signed [D_W-1:0]    d_prod, d_r;
  logic signed [DEN0_W-1:0] den0_prod;
  logic signed [TC_W-1:0]   tc;
  logic signed [DEN_W-1:0]  den_c;
  logic [LOP_W-1:0]         lo_prod, lop_r;
  logic signed [HIP_W-1:0]  hi_prod;
  logic signed [NUMC_W-1:0] num_r;
  logic signed [DEN_W-1:0]  den_r;

  assign dv        = $signed({1'b0, p2mv_r}) - $signed({1'b0, p1mv_r});
  assign n_s       = $signed({1'b0, cnt_r});
  assign v1_s      = $signed({1'b0, p1val_r});
  assign dval      = $signed({1'b0, p2val_r}) - $signed({1'b0, p1val_r});
  assign a_prod    = v1_s * dv;
  assign an_prod   = a_r * n_s;
  assign b_prod    = p1mv_r * cnt_r;
  assign c_nxt     = $signed({{(C_W-SUM_W){1'b0}}, sum_r}) - $signed({1'b0, b_r});
  assign d_prod    = dval * c_r;
  assign den0_prod = dv * n_s;
  assign tc        = $signed({temp_r[T_W-1], temp_r}) + TC_W'(T_OFFSET);
  assign den_c     = $signed(den_r[DEN0_W-1:0]) * tc;
  assign lo_prod   = num_r[LO_W-1:0] * COMP_SCALE[SCALE_W-2:0];
  assign hi_prod   = $signed(num_r[NUM0_W-1:LO_W]) * COMP_SCALE;

  // Magnitudes and signs for the final division.
  logic              num_neg, den_neg, res_neg, den_zero, num_zero;
  logic [NUMC_W-1:0] num_mag;
  logic [DEN_W-1:0]  den_mag;
  logic [DVD_W-1:0]  dvd_big;
  logic [SUM_W:0]    mean_dvd;

  assign num_neg  = num_r[NUMC_W-1];
  assign den_neg  = den_r[DEN_W-1];
  assign res_neg  = num_neg ^ den_neg;
  assign den_zero = (den_r == '0);
  assign num_zero = (num_r == '0);
  assign num_mag  = num_neg ? NUMC_W'(-num_r) : NUMC_W'(num_r);
  assign den_mag  = den_neg ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign dvd_big  = {1'b0, num_mag} + DVD_W'(den_mag >> 1);
  assign mean_dvd = {1'b0, sum_r} + (SUM_W+1)'(cnt_r >> 1);

  // Shared serial divider: mean first, then the calibration ratio.
  logic             div_go;
  logic [STP_W-1:0] div_steps;
  logic [DVD_W-1:0] div_dvd;
  logic [DEN_W-1:0] div_dvs;
  logic [Q_W-1:0]   div_q;
  div_stat_t        div_st;

  assign div_go    = (state_r == S_MEAN) || (state_r == S_DIVS && !den_zero);
  assign div_steps = (state_r == S_MEAN) ? STP_W'(SUM_W + 1) : STP_W'(DVD_W);
  assign div_dvd   = (state_r == S_MEAN) ? (DVD_W'(mean_dvd) << MEAN_SH) : dvd_big;
  assign div_dvs   = (state_r == S_MEAN) ? DEN_W'(cnt_r) : den_mag;

  ptpc_sdiv #(
    .DVD_W (DVD_W),
    .DVS_W (DEN_W),
    .STP_W (STP_W)
  ) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .steps    (div_steps),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_st)
  );

  // Saturation of the divided result.
  logic                   clip;
  logic signed [RD_W-1:0] q_signed;

  assign clip     = div_st.ovf || (res_neg ? (div_q > READ_MIN_Q) : (div_q > READ_MAX_Q));
  assign q_signed = res_neg ? -$signed(div_q[RD_W-1:0]) : $signed(div_q[RD_W-1:0]);

  // Result holding registers and output register.
  logic [MV_W-1:0]        mean_r;
  logic signed [RD_W-1:0] read_r;
  logic                   rv_r;
  logic                   sat_r;
  logic                   out_valid_r;
  logic [MV_W-1:0]        out_mean_r;
  logic signed [RD_W-1:0] out_read_r;
  logic                   out_rv_r;
  logic                   out_sat_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result beat empties the output register unless the next one is loaded now.
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sample_r <= in_sample_mv;
            temp_r   <= in_temperature_centi;
            if (in_func) begin
              sum_r   <= '0;
              cnt_r   <= '0;
              slot_r  <= '0;
              mean_r  <= '0;
              read_r  <= '0;
              rv_r    <= 1'b0;
              sat_r   <= 1'b0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          sum_r   <= sum_nxt;
          cnt_r   <= full ? cnt_r : cnt_r + 1'b1;
          slot_r  <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
          rv_r    <= cal_rdy_r;
          read_r  <= '0;
          sat_r   <= 1'b0;
          state_r <= S_MEAN;
        end
        S_MEAN: begin
          state_r <= S_MEAN_W;
        end
        S_MEAN_W: begin
          if (div_st.done) begin
            mean_r  <= div_q[MV_W-1:0];
            state_r <= cal_rdy_r ? S_CAL0 : S_FIN;
          end
        end
        S_CAL0: begin
          a_r     <= a_prod;
          b_r     <= b_prod;
          den_r   <= DEN_W'(den0_prod);
          state_r <= S_CAL1;
        end
        S_CAL1: begin
          an_r    <= an_prod;
          c_r     <= c_nxt;
          state_r <= S_CAL2;
        end
        S_CAL2: begin
          d_r     <= d_prod;
          state_r <= S_CAL3;
        end
        S_CAL3: begin
          // Equal point voltages give the first point's value.
          if (dv == '0) begin
            num_r <= NUMC_W'(v1_s);
            den_r <= DEN_W'(1);
          end else begin
            num_r <= NUMC_W'(an_r) + NUMC_W'(d_r);
          end
          state_r <= tcomp_r ? S_CMP0 : S_DIVS;
        end
        S_CMP0: begin
          lop_r   <= lo_prod;
          den_r   <= den_c;
          state_r <= S_CMP1;
        end
        S_CMP1: begin
          num_r   <= (NUMC_W'(hi_prod) << LO_W) + NUMC_W'(lop_r);
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          // A zero denominator saturates toward the numerator's sign, or gives zero for a zero numerator.
          if (den_zero) begin
            sat_r   <= !num_zero;
            read_r  <= num_zero ? '0 : (num_neg ? READ_MIN : READ_MAX);
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_st.done) begin
            sat_r   <= clip;
            read_r  <= clip ? (res_neg ? READ_MIN : READ_MAX) : q_signed;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= mean_r;
            out_read_r  <= read_r;
            out_rv_r    <= rv_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_mv       = out_mean_r;
  assign out_reading       = out_read_r;
  assign out_reading_valid = out_rv_r;
  assign out_saturated     = out_sat_r;

endmodule

// ===== rtl/ptpc_chk.sv =====
// Port-level checker for the probe calibration block, bound to the top level.
module ptpc_chk import ptpc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [RD_W-1:0] out_reading,
  input logic                   out_reading_valid,
  input logic                   out_saturated
);

  // A beat without calibration carries no reading.
  a_no_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reading_valid |-> out_reading == '0 && !out_saturated)
    else $error("reading present without calibration");

  // A clipped reading sits at one of the limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_reading == READ_MAX || out_reading == READ_MIN)
    else $error("saturated reading not at a limit");

  // The block never takes a new beat in the cycle right after taking one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // A stalled result beat holds its reading.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reading))
    else $error("result beat changed while stalled");

endmodule

bind probe_two_point_calibration_top ptpc_chk u_ptpc_chk (.*);
